[rtl/core/assert_macros.svh]
// Assertion macros shared by the integrator RTL.
// RK_ASSERT checks a property outside reset; RK_ASSERT_NOW checks it at every edge.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define RK_ASSERT(lbl, clk, rstn, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rstn) prop) else $error(msg);
`define RK_ASSERT_NOW(lbl, clk, prop, msg) \
	lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define RK_ASSERT(lbl, clk, rstn, prop, msg)
`define RK_ASSERT_NOW(lbl, clk, prop, msg)
`endif
`endif

[rtl/core/rk4si_pkg.sv]
package rk4si_pkg;

	localparam int DATA_WIDTH_DEF = 32;
	localparam int FRAC_BITS_DEF  = 16;

	localparam int STEP_W = 31;
	localparam logic [STEP_W-1:0] STEP_RESET = 31'd65536;

	typedef enum logic [1:0] {
		STG_START,
		STG_MID_A,
		STG_MID_B,
		STG_FINAL
	} stage_t;

	typedef struct packed {
		logic   vld;
		stage_t idx;
		logic   neg;
	} ctl_t;

	// radix-256 division by six: one digit per pipeline stage
	localparam int DIG_W     = 8;
	localparam int REM_W     = 3;
	localparam int RECIP_W   = 10;
	localparam int PROD_W    = DIG_W + REM_W + RECIP_W;
	localparam int DIVISOR   = 6;
	localparam int DIV_RECIP = 683;
	localparam int DIV_SHIFT = 12;

	typedef struct packed {
		logic [DIG_W-1:0] quo;
		logic [REM_W-1:0] rem;
	} digit_t;

	// v = rem*256 + digit < 1536; 683/4096 stays close enough to 1/6 to floor exactly
	function automatic digit_t div6_digit(input logic [DIG_W+REM_W-1:0] v);
		logic [PROD_W-1:0]      prod;
		logic [DIG_W+REM_W-1:0] back;
		digit_t                 res;
		prod    = PROD_W'(v) * PROD_W'(DIV_RECIP);
		res.quo = prod[DIV_SHIFT +: DIG_W];
		back    = (DIG_W+REM_W)'(res.quo) * (DIG_W+REM_W)'(DIVISOR);
		res.rem = REM_W'(v - back);
		return res;
	endfunction

endpackage

[rtl/core/rk4si_ctrl.sv]
`include "assert_macros.svh"

module rk4si_ctrl #(
	parameter int DATA_WIDTH = 32
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            adv,
	input  logic                            in_valid,
	input  logic signed [DATA_WIDTH-1:0]    state_value,
	input  logic signed [DATA_WIDTH-1:0]    derivative,
	input  logic                            restart,
	input  logic                            cfg_wr_en,
	input  logic [rk4si_pkg::STEP_W-1:0]    cfg_wr_data,
	output rk4si_pkg::ctl_t                 ctl_s1,
	output logic signed [DATA_WIDTH+2:0]    op_s1,
	output logic [rk4si_pkg::STEP_W-1:0]    step_s1,
	output logic signed [DATA_WIDTH-1:0]    x0_s1
);
	import rk4si_pkg::*;

	localparam int KW = DATA_WIDTH + 3;

	stage_t                      stage_q;
	stage_t                      cur;
	logic [STEP_W-1:0]           step_q;
	logic signed [DATA_WIDTH-1:0] start_q;
	logic signed [KW-1:0]        wsum_q;
	logic                        acc;
	logic signed [KW-1:0]        d_ext;
	logic signed [KW-1:0]        op_d;
	logic [STEP_W-1:0]           h_d;

	assign acc   = in_valid && adv;
	assign cur   = restart ? STG_START : stage_q;
	assign d_ext = KW'(derivative);

	// pick step and slope operand for this stage
	always_comb begin
		op_d = d_ext;
		h_d  = step_q >> 1;
		case (cur)
			STG_START, STG_MID_A: h_d = step_q >> 1;
			STG_MID_B: h_d = step_q;
			STG_FINAL: begin
				h_d  = step_q;
				op_d = wsum_q + d_ext;
			end
			default: h_d = step_q >> 1;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			step_q <= STEP_RESET;
		end else if (cfg_wr_en) begin
			step_q <= cfg_wr_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			stage_q <= STG_START;
			ctl_s1  <= '0;
		end else if (adv) begin
			if (acc) begin
				stage_q <= stage_t'(2'(cur + 2'd1));
			end
			ctl_s1 <= '{vld: acc, idx: cur, neg: op_d[KW-1]};
		end
	end

	// running weighted slope sum k1 + 2k2 + 2k3
	always_ff @(posedge clk) begin
		if (acc) begin
			case (cur)
				STG_START: begin
					start_q <= state_value;
					wsum_q  <= d_ext;
				end
				STG_MID_A, STG_MID_B: wsum_q <= wsum_q + d_ext + d_ext;
				default: wsum_q <= wsum_q;
			endcase
		end
		if (adv) begin
			op_s1   <= op_d;
			step_s1 <= h_d;
			x0_s1   <= (cur == STG_START) ? state_value : start_q;
		end
	end

	`RK_ASSERT(a_restart_first, clk, arst_n, (acc && restart) |=> (ctl_s1.idx == STG_START), "restart did not force first stage")
	`RK_ASSERT(a_stage_adv, clk, arst_n, (acc && !restart) |=> (stage_q == stage_t'(2'($past(stage_q) + 2'd1))), "stage did not advance")

endmodule

[rtl/core/rk4si_mul.sv]
module rk4si_mul #(
	parameter int DATA_WIDTH = 32,
	parameter int FRAC_BITS  = 16
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            adv,
	input  rk4si_pkg::ctl_t                 ctl_s1,
	input  logic signed [DATA_WIDTH+2:0]    op_s1,
	input  logic [rk4si_pkg::STEP_W-1:0]    step_s1,
	input  logic signed [DATA_WIDTH-1:0]    x0_s1,
	output rk4si_pkg::ctl_t                 ctl_s4,
	output logic [DATA_WIDTH+3:0]           mag_s4,
	output logic signed [DATA_WIDTH-1:0]    x0_s4
);
	import rk4si_pkg::*;

	localparam int KW    = DATA_WIDTH + 3;
	localparam int MAG_W = DATA_WIDTH + 2;
	localparam int LO_W  = (MAG_W + 1) / 2;
	localparam int HI_W  = MAG_W - LO_W;
	localparam int LPW   = STEP_W + LO_W;
	localparam int HPW   = STEP_W + HI_W;
	localparam int PW    = STEP_W + MAG_W;
	localparam int SW    = PW - FRAC_BITS;
	localparam int QW    = DATA_WIDTH + 4;
	localparam int EW    = (SW > QW) ? SW : QW;

	ctl_t                         ctl_s2, ctl_s3;
	logic [MAG_W-1:0]             mag_s2;
	logic [STEP_W-1:0]            step_s2;
	logic signed [DATA_WIDTH-1:0] x0_s2, x0_s3;
	logic [LPW-1:0]               plo_s3;
	logic [HPW-1:0]               phi_s3;
	logic [PW-1:0]                prod;
	logic [EW-1:0]                sc_ext;
	logic [EW-1:0]                cap;

	// recombine partial products, drop fraction bits, hold huge values at 2^(DATA_WIDTH+3)
	assign prod   = (PW'(phi_s3) << LO_W) + PW'(plo_s3);
	assign sc_ext = EW'(SW'(prod >> FRAC_BITS));
	assign cap    = EW'(1) << (QW - 1);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctl_s2 <= '0;
			ctl_s3 <= '0;
			ctl_s4 <= '0;
		end else if (adv) begin
			ctl_s2 <= ctl_s1;
			ctl_s3 <= ctl_s2;
			ctl_s4 <= ctl_s3;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			mag_s2  <= op_s1[KW-1] ? MAG_W'(-op_s1) : MAG_W'(op_s1);
			step_s2 <= step_s1;
			x0_s2   <= x0_s1;
			plo_s3  <= LPW'(step_s2) * LPW'(mag_s2[LO_W-1:0]);
			phi_s3  <= HPW'(step_s2) * HPW'(mag_s2[MAG_W-1:LO_W]);
			x0_s3   <= x0_s2;
			mag_s4  <= (sc_ext > cap) ? QW'(cap) : QW'(sc_ext);
			x0_s4   <= x0_s3;
		end
	end

endmodule

[rtl/core/rk4si_div.sv]
module rk4si_div #(
	parameter int DATA_WIDTH = 32
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            adv,
	input  rk4si_pkg::ctl_t                 ctl_in,
	input  logic [DATA_WIDTH+3:0]           mag_in,
	input  logic signed [DATA_WIDTH-1:0]    x0_in,
	output rk4si_pkg::ctl_t                 ctl_out,
	output logic [DATA_WIDTH+3:0]           mag_out,
	output logic signed [DATA_WIDTH-1:0]    x0_out
);
	import rk4si_pkg::*;

	localparam int QW   = DATA_WIDTH + 4;
	localparam int NDIG = (QW + DIG_W - 1) / DIG_W;
	localparam int PADW = NDIG * DIG_W;

	logic [PADW-1:0]              word_q [NDIG];
	logic [REM_W-1:0]             rem_q  [NDIG];
	ctl_t                         ctl_q  [NDIG];
	logic signed [DATA_WIDTH-1:0] x0_q   [NDIG];

	// one quotient digit per stage, most significant first; other stages pass digits through
	for (genvar j = 0; j < NDIG; j++) begin : g_dig
		localparam int POS = (NDIG - 1 - j) * DIG_W;
		logic [PADW-1:0]              w_in, w_nx;
		logic [REM_W-1:0]             r_in;
		ctl_t                         c_in;
		logic signed [DATA_WIDTH-1:0] x_in;
		digit_t                       dg;

		if (j == 0) begin : g_head
			assign w_in = PADW'(mag_in);
			assign r_in = '0;
			assign c_in = ctl_in;
			assign x_in = x0_in;
		end else begin : g_tail
			assign w_in = word_q[j-1];
			assign r_in = rem_q[j-1];
			assign c_in = ctl_q[j-1];
			assign x_in = x0_q[j-1];
		end

		always_comb begin
			w_nx = w_in;
			dg   = '{quo: w_in[POS +: DIG_W], rem: '0};
			if (c_in.idx == STG_FINAL) begin
				dg = div6_digit({r_in, w_in[POS +: DIG_W]});
			end
			w_nx[POS +: DIG_W] = dg.quo;
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				ctl_q[j] <= '0;
			end else if (adv) begin
				ctl_q[j] <= c_in;
			end
		end

		always_ff @(posedge clk) begin
			if (adv) begin
				word_q[j] <= w_nx;
				rem_q[j]  <= dg.rem;
				x0_q[j]   <= x_in;
			end
		end
	end

	assign ctl_out = ctl_q[NDIG-1];
	assign mag_out = word_q[NDIG-1][QW-1:0];
	assign x0_out  = x0_q[NDIG-1];

endmodule

[rtl/core/rk4si_out.sv]
`include "assert_macros.svh"

module rk4si_out #(
	parameter int DATA_WIDTH = 32
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            adv,
	input  rk4si_pkg::ctl_t                 ctl_in,
	input  logic [DATA_WIDTH+3:0]           mag_in,
	input  logic signed [DATA_WIDTH-1:0]    x0_in,
	output logic                            out_valid,
	output logic signed [DATA_WIDTH-1:0]    next_value,
	output logic [1:0]                      stage_index,
	output logic                            final_res,
	output logic                            saturated
);
	import rk4si_pkg::*;

	localparam int QW   = DATA_WIDTH + 4;
	localparam int SUMW = QW + 2;
	localparam logic signed [SUMW-1:0] DMAX = SUMW'({1'b0, {(DATA_WIDTH-1){1'b1}}});
	localparam logic signed [SUMW-1:0] DMIN = ~DMAX;

	logic signed [QW:0]      sv;
	logic signed [SUMW-1:0]  sum;
	logic                    sat_hi, sat_lo;

	// reapply sign, add start value, clamp to the data range
	assign sv     = ctl_in.neg ? -$signed({1'b0, mag_in}) : $signed({1'b0, mag_in});
	assign sum    = SUMW'(x0_in) + SUMW'(sv);
	assign sat_hi = sum > DMAX;
	assign sat_lo = sum < DMIN;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid <= 1'b0;
		end else if (adv) begin
			out_valid <= ctl_in.vld;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			next_value  <= sat_hi ? DMAX[DATA_WIDTH-1:0] :
				sat_lo ? DMIN[DATA_WIDTH-1:0] : sum[DATA_WIDTH-1:0];
			stage_index <= ctl_in.idx;
			final_res   <= (ctl_in.idx == STG_FINAL);
			saturated   <= sat_hi || sat_lo;
		end
	end

	`RK_ASSERT(a_sat_rail, clk, arst_n, (out_valid && saturated) |-> ((next_value == DMAX[DATA_WIDTH-1:0]) || (next_value == DMIN[DATA_WIDTH-1:0])), "saturated result off the rails")
	`RK_ASSERT_NOW(a_rst_empty, clk, (!arst_n) |-> (!out_valid), "result valid during reset")

endmodule

[rtl/core/rk4_stage_integrator_unit.sv]
// Channel  Handshake            Fields                                         Transfer when
// input    in_valid/in_ready    state_value, derivative, restart               valid && ready
// result   out_valid/out_ready  next_value, stage_index, final_res, saturated  valid && ready
// config   cfg_wr_en            cfg_wr_data (step size h)                      cfg_wr_en
//
// A transfer loads the control stage; its result then passes three stages for the split multiply,
// one per byte of the divide-by-six digit chain and one for the result register. One item can
// transfer every cycle while the result register is empty or being taken.
// arst_n clears the stage counter, the valid bits and the step size (to 1.0).
// When the result register is full and not taken, every stage holds and in_ready drops.
module rk4_stage_integrator_unit #(
	parameter int DATA_WIDTH = rk4si_pkg::DATA_WIDTH_DEF,
	parameter int FRAC_BITS  = rk4si_pkg::FRAC_BITS_DEF
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            in_valid,
	output logic                            in_ready,
	input  logic signed [DATA_WIDTH-1:0]    state_value,
	input  logic signed [DATA_WIDTH-1:0]    derivative,
	input  logic                            restart,
	output logic                            out_valid,
	input  logic                            out_ready,
	output logic signed [DATA_WIDTH-1:0]    next_value,
	output logic [1:0]                      stage_index,
	output logic                            final_res,
	output logic                            saturated,
	input  logic                            cfg_wr_en,
	input  logic [rk4si_pkg::STEP_W-1:0]    cfg_wr_data
);
	import rk4si_pkg::*;

	// global advance: the whole pipe moves whenever the result register can take a value
	logic                         adv;
	ctl_t                         ctl_s1, ctl_s4, ctl_dv;
	logic signed [DATA_WIDTH+2:0] op_s1;
	logic [STEP_W-1:0]            step_s1;
	logic signed [DATA_WIDTH-1:0] x0_s1, x0_s4, x0_dv;
	logic [DATA_WIDTH+3:0]        mag_s4, mag_dv;

	assign adv      = !out_valid || out_ready;
	assign in_ready = adv;

	// stage counter, start value and slope sum; picks h or h/2 and the slope operand
	rk4si_ctrl #(
		.DATA_WIDTH(DATA_WIDTH)
	) u_ctrl (
		.clk        (clk),
		.arst_n     (arst_n),
		.adv        (adv),
		.in_valid   (in_valid),
		.state_value(state_value),
		.derivative (derivative),
		.restart    (restart),
		.cfg_wr_en  (cfg_wr_en),
		.cfg_wr_data(cfg_wr_data),
		.ctl_s1     (ctl_s1),
		.op_s1      (op_s1),
		.step_s1    (step_s1),
		.x0_s1      (x0_s1)
	);

	// |slope| * step in two half-width products, rescaled and capped
	rk4si_mul #(
		.DATA_WIDTH(DATA_WIDTH),
		.FRAC_BITS (FRAC_BITS)
	) u_mul (
		.clk    (clk),
		.arst_n (arst_n),
		.adv    (adv),
		.ctl_s1 (ctl_s1),
		.op_s1  (op_s1),
		.step_s1(step_s1),
		.x0_s1  (x0_s1),
		.ctl_s4 (ctl_s4),
		.mag_s4 (mag_s4),
		.x0_s4  (x0_s4)
	);

	// truncating divide by six on the final stage only
	rk4si_div #(
		.DATA_WIDTH(DATA_WIDTH)
	) u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.adv    (adv),
		.ctl_in (ctl_s4),
		.mag_in (mag_s4),
		.x0_in  (x0_s4),
		.ctl_out(ctl_dv),
		.mag_out(mag_dv),
		.x0_out (x0_dv)
	);

	// sign, add to start value, saturate, hold result for transfer
	rk4si_out #(
		.DATA_WIDTH(DATA_WIDTH)
	) u_out (
		.clk        (clk),
		.arst_n     (arst_n),
		.adv        (adv),
		.ctl_in     (ctl_dv),
		.mag_in     (mag_dv),
		.x0_in      (x0_dv),
		.out_valid  (out_valid),
		.next_value (next_value),
		.stage_index(stage_index),
		.final_res  (final_res),
		.saturated  (saturated)
	);

endmodule

[sim/rk4_stage_integrator_unit_tb.sv]
module rk4_stage_integrator_unit_tb;
	timeunit 1ns;
	timeprecision 1ps;

	import rk4si_pkg::*;

	localparam int DW = DATA_WIDTH_DEF;
	localparam int FB = FRAC_BITS_DEF;
	// pipeline span from an input transfer to its result: multiply, divide chain, output reg
	localparam int LATENCY = 4 + (DW + 4 + 7) / 8;
	localparam int HOLD_CYCLES = 300;
	localparam int PHASE_ITEMS = 110;
	localparam longint VALUE_MAX = (64'sd1 <<< (DW - 1)) - 1;
	localparam longint VALUE_MIN = -VALUE_MAX - 1;
	localparam logic [63:0] MAG_CAP = 64'd1 << 62;

	localparam logic signed [DW-1:0] Q_MAX = {1'b0, {(DW-1){1'b1}}};
	localparam logic signed [DW-1:0] Q_MIN = {1'b1, {(DW-1){1'b0}}};
	localparam logic signed [DW-1:0] Q_ONE = 1 <<< FB;

	typedef struct packed {
		logic signed [DW-1:0] value;
		stage_t               idx;
		logic                 fin;
		logic                 sat;
	} rk4_point_t;

	// one row of the directed walk; typed rows carry a hand-computed result
	typedef struct packed {
		logic signed [DW-1:0] x;
		logic signed [DW-1:0] d;
		logic                 rst;
		logic                 typed;
		rk4_point_t           res;
	} stim_row_t;

	localparam rk4_point_t NO_CHECK = '{'0, STG_START, 1'b0, 1'b0};

	logic                 clk;
	logic                 arst_n;
	logic                 in_valid;
	logic                 in_ready;
	logic signed [DW-1:0] state_value;
	logic signed [DW-1:0] derivative;
	logic                 restart;
	logic                 out_valid;
	logic                 out_ready;
	logic signed [DW-1:0] next_value;
	logic [1:0]           stage_index;
	logic                 final_res;
	logic                 saturated;
	logic                 cfg_wr_en;
	logic [STEP_W-1:0]    cfg_wr_data;

	// predictor state: step size, stage counter, start value and held slopes
	logic [STEP_W-1:0]    step_h;
	stage_t               stage_ctr;
	logic signed [DW-1:0] x0_point;
	logic signed [DW-1:0] k1_slope;
	logic signed [DW-1:0] k2_slope;
	logic signed [DW-1:0] k3_slope;

	rk4_point_t expected_points[$];
	rk4_point_t oldest_point;
	int         fail_count;
	logic       quiet;
	logic       hold_request;

	stim_row_t directed_rows [0:23] = '{
		// zero start, zero slopes: every stage gives zero
		'{'0, '0, 1'b1, 1'b1, '{'0, STG_START, 1'b0, 1'b0}},
		'{Q_ONE, '0, 1'b0, 1'b1, '{'0, STG_MID_A, 1'b0, 1'b0}},
		'{'0, '0, 1'b0, 1'b1, '{'0, STG_MID_B, 1'b0, 1'b0}},
		'{'0, '0, 1'b0, 1'b1, '{'0, STG_FINAL, 1'b1, 1'b0}},
		// positive extremes clamp high in every stage
		'{Q_MAX, Q_MAX, 1'b1, 1'b1, '{Q_MAX, STG_START, 1'b0, 1'b1}},
		'{'0, Q_MAX, 1'b0, 1'b1, '{Q_MAX, STG_MID_A, 1'b0, 1'b1}},
		'{'0, Q_MAX, 1'b0, 1'b1, '{Q_MAX, STG_MID_B, 1'b0, 1'b1}},
		'{'0, Q_MAX, 1'b0, 1'b1, '{Q_MAX, STG_FINAL, 1'b1, 1'b1}},
		// negative extremes clamp low in every stage
		'{Q_MIN, Q_MIN, 1'b1, 1'b1, '{Q_MIN, STG_START, 1'b0, 1'b1}},
		'{'0, Q_MIN, 1'b0, 1'b1, '{Q_MIN, STG_MID_A, 1'b0, 1'b1}},
		'{'0, Q_MIN, 1'b0, 1'b1, '{Q_MIN, STG_MID_B, 1'b0, 1'b1}},
		'{'0, Q_MIN, 1'b0, 1'b1, '{Q_MIN, STG_FINAL, 1'b1, 1'b1}},
		// 1.0 + 0.5 * 2.0
		'{Q_ONE, 32'sh0002_0000, 1'b1, 1'b1, '{32'sh0002_0000, STG_START, 1'b0, 1'b0}},
		// state_value must be ignored past the first stage
		'{32'sh1234_5678, 32'sh0003_0000, 1'b0, 1'b0, NO_CHECK},
		'{'0, 32'shFFFE_8000, 1'b0, 1'b0, NO_CHECK},
		'{'0, 32'sd7, 1'b0, 1'b0, NO_CHECK},
		// negative slopes: products and the divide by six truncate toward zero
		'{32'shFFFF_0000, 32'shFFFF_FFFF, 1'b1, 1'b0, NO_CHECK},
		'{'0, 32'shFFFF_FFFB, 1'b0, 1'b0, NO_CHECK},
		'{'0, 32'shFFFF_FFFD, 1'b0, 1'b0, NO_CHECK},
		'{'0, 32'shFFFF_FFF9, 1'b0, 1'b0, NO_CHECK},
		// wrap into a new step without restart, then restart mid step
		'{32'sh0005_0000, Q_ONE, 1'b0, 1'b0, NO_CHECK},
		'{32'sh0004_0000, 32'sh0000_8000, 1'b1, 1'b0, NO_CHECK},
		'{32'sh7FFF_0000, Q_MAX, 1'b1, 1'b0, NO_CHECK},
		'{'0, '0, 1'b0, 1'b0, NO_CHECK}
	};

	rk4_stage_integrator_unit #(
		.DATA_WIDTH(DW),
		.FRAC_BITS (FB)
	) DUT (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (in_valid),
		.in_ready   (in_ready),
		.state_value(state_value),
		.derivative (derivative),
		.restart    (restart),
		.out_valid  (out_valid),
		.out_ready  (out_ready),
		.next_value (next_value),
		.stage_index(stage_index),
		.final_res  (final_res),
		.saturated  (saturated),
		.cfg_wr_en  (cfg_wr_en),
		.cfg_wr_data(cfg_wr_data)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// step times slope magnitude, scaled down by the fraction bits, capped, divided,
	// sign put back
	function automatic longint scale_by_step(input logic [STEP_W-1:0] h, input longint k,
			input logic [63:0] divisor);
		logic [63:0]  mag;
		logic [127:0] prod;
		logic [63:0]  q;
		mag  = (k < 0) ? 64'(-k) : 64'(k);
		prod = (128'(h) * 128'(mag)) >> FB;
		q    = (prod > 128'(MAG_CAP)) ? MAG_CAP : prod[63:0];
		q    = q / divisor;
		return (k < 0) ? -longint'(q) : longint'(q);
	endfunction

	// advance the integrator by one item and return the point it emits
	function automatic rk4_point_t rk4_advance(input logic signed [DW-1:0] x,
			input logic signed [DW-1:0] d, input logic rst);
		rk4_point_t        r;
		stage_t            s;
		longint            sum;
		longint            weighted;
		logic [STEP_W-1:0] half;
		half = step_h >> 1;
		s    = rst ? STG_START : stage_ctr;
		case (s)
			STG_START: begin
				x0_point = x;
				k1_slope = d;
				sum      = longint'(x0_point) + scale_by_step(half, longint'(d), 64'd1);
			end
			STG_MID_A: begin
				k2_slope = d;
				sum      = longint'(x0_point) + scale_by_step(half, longint'(d), 64'd1);
			end
			STG_MID_B: begin
				k3_slope = d;
				sum      = longint'(x0_point) + scale_by_step(step_h, longint'(d), 64'd1);
			end
			default: begin
				weighted = longint'(k1_slope) + 2 * longint'(k2_slope)
					+ 2 * longint'(k3_slope) + longint'(d);
				sum = longint'(x0_point) + scale_by_step(step_h, weighted, 64'd6);
			end
		endcase
		r.sat = 1'b0;
		if (sum > VALUE_MAX) begin
			sum   = VALUE_MAX;
			r.sat = 1'b1;
		end else if (sum < VALUE_MIN) begin
			sum   = VALUE_MIN;
			r.sat = 1'b1;
		end
		r.value   = sum[DW-1:0];
		r.idx     = s;
		r.fin     = (s == STG_FINAL);
		stage_ctr = stage_t'(2'(s + 2'd1));
		return r;
	endfunction

	// mostly small values so the result stays in range, with full-width and extremes mixed in
	function automatic logic signed [DW-1:0] pick_q16();
		case ($urandom_range(0, 9))
			0, 1:    return DW'(int'($urandom_range(0, 512)) - 256);
			2, 3, 4: return DW'(int'($urandom_range(0, 32'h0020_0000)) - 32'sh0010_0000);
			5, 6:    return DW'($urandom);
			7:       return Q_MAX;
			8:       return Q_MIN;
			default: return DW'(int'($urandom_range(0, 32'h0200_0000)) - 32'sh0100_0000);
		endcase
	endfunction

	function automatic int pick_gap();
		return (quiet || $urandom_range(0, 3) != 0) ? 0 : int'($urandom_range(1, 14));
	endfunction

	// Offer one item after an optional idle gap; hold valid and payload until the transfer,
	// then queue what the integrator should emit for it.
	task automatic offer(input logic signed [DW-1:0] x, input logic signed [DW-1:0] d,
			input logic rst, input int gap, input logic typed, input rk4_point_t typed_res);
		rk4_point_t predicted;
		if (gap > 0) begin
			@(negedge clk);
			in_valid = 1'b0;
			repeat (gap - 1) @(negedge clk);
		end
		@(negedge clk);
		in_valid    = 1'b1;
		state_value = x;
		derivative  = d;
		restart     = rst;
		do @(posedge clk); while (!in_ready);
		// typed rows still run the predictor so its state tracks the block
		predicted = rk4_advance(x, d, rst);
		expected_points.push_back(typed ? typed_res : predicted);
	endtask

	task automatic end_burst();
		@(negedge clk);
		in_valid = 1'b0;
	endtask

	// Change the step only with nothing in flight; every item yields a result, so an
	// empty queue means the pipeline is empty.
	task automatic load_step(input logic [STEP_W-1:0] h);
		while (expected_points.size() != 0) @(posedge clk);
		@(negedge clk);
		cfg_wr_en   = 1'b1;
		cfg_wr_data = h;
		@(negedge clk);
		cfg_wr_en = 1'b0;
		step_h    = h;
	endtask

	// One phase at one step size: mostly complete four-stage steps with random content,
	// the rest single items with a random restart bit.
	task automatic run_phase(input logic [STEP_W-1:0] h, input int items, input logic long_hold);
		int   sent;
		logic rst;
		load_step(h);
		// stall the result side while the sender keeps pushing, so in_ready must drop
		if (long_hold)
			hold_request = 1'b1;
		sent = 0;
		while (sent < items) begin
			if ($urandom_range(0, 7) != 0) begin
				for (int n = 0; n < 4; n++) begin
					rst = (n == 0) ? ((stage_ctr != STG_START) || ($urandom_range(0, 1) == 1))
						: 1'b0;
					offer(pick_q16(), pick_q16(), rst, pick_gap(), 1'b0, NO_CHECK);
				end
				sent += 4;
			end else begin
				offer(pick_q16(), pick_q16(), 1'($urandom_range(0, 1)), pick_gap(), 1'b0,
					NO_CHECK);
				sent++;
			end
		end
		end_burst();
	endtask

	// Result side: random ready bursts, a long hold-off on request, steady ready when quiet.
	initial begin
		out_ready = 1'b0;
		@(posedge arst_n);
		@(negedge clk);
		forever begin
			if (hold_request) begin
				out_ready = 1'b0;
				repeat (HOLD_CYCLES) @(negedge clk);
				hold_request = 1'b0;
			end else if (quiet || $urandom_range(0, 2) != 0) begin
				out_ready = 1'b1;
				repeat ($urandom_range(1, 30)) @(negedge clk);
			end else begin
				out_ready = 1'b0;
				repeat ($urandom_range(1, 14)) @(negedge clk);
			end
		end
	end

	// Check every result transfer against the oldest expected point.
	always @(posedge clk) begin
		if (arst_n && out_valid && out_ready) begin
			if (expected_points.size() == 0) begin
				fail_count++;
				if (fail_count <= 10)
					$display("unexpected result: value %h stage %0d final %0b sat %0b",
						next_value, stage_index, final_res, saturated);
			end else begin
				oldest_point = expected_points.pop_front();
				if (next_value !== oldest_point.value || stage_index !== oldest_point.idx
						|| final_res !== oldest_point.fin || saturated !== oldest_point.sat) begin
					fail_count++;
					if (fail_count <= 10)
						$display("mismatch: expected %h/%0d/%0b/%0b, got %h/%0d/%0b/%0b",
							oldest_point.value, oldest_point.idx, oldest_point.fin,
							oldest_point.sat, next_value, stage_index, final_res, saturated);
				end
			end
		end
	end

	// Drive reset, walk the directed rows, then the random phases, then drain and report.
	initial begin
		arst_n       = 1'b0;
		in_valid     = 1'b0;
		state_value  = '0;
		derivative   = '0;
		restart      = 1'b0;
		cfg_wr_en    = 1'b0;
		cfg_wr_data  = '0;
		quiet        = 1'b0;
		hold_request = 1'b0;
		fail_count   = 0;
		step_h       = STEP_RESET;
		stage_ctr    = STG_START;
		x0_point     = '0;
		k1_slope     = '0;
		k2_slope     = '0;
		k3_slope     = '0;
		repeat (9) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// directed walk runs at the reset step of 1.0
		for (int i = 0; i < $size(directed_rows); i++)
			offer(directed_rows[i].x, directed_rows[i].d, directed_rows[i].rst, pick_gap(),
				directed_rows[i].typed, directed_rows[i].res);
		end_burst();

		run_phase(31'h7FFF_FFFF, PHASE_ITEMS, 1'b1);
		run_phase('0, PHASE_ITEMS, 1'b0);
		run_phase(31'd1, PHASE_ITEMS, 1'b0);
		run_phase(31'h0000_8000, PHASE_ITEMS, 1'b0);
		run_phase(31'($urandom_range(0, 32'h0004_0000)), PHASE_ITEMS, 1'b0);
		run_phase(31'($urandom), PHASE_ITEMS, 1'b0);
		run_phase(31'h4000_0001, PHASE_ITEMS, 1'b0);
		// closing stretch: no idling on either side
		quiet = 1'b1;
		run_phase(STEP_RESET, PHASE_ITEMS, 1'b0);

		while (expected_points.size() != 0) @(posedge clk);
		repeat (2 * LATENCY) @(posedge clk);
		if (fail_count == 0)
			$display("TEST PASSED");
		else
			$display("TEST FAILED");
		$finish;
	end

	// Watchdog: far beyond the slowest correct run.
	initial begin
		#5_000_000;
		$display("TEST FAILED");
		$finish;
	end

endmodule
